### rtl/npcm_pkg.sv
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types and constants of the nearest palette color mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package npcm_pkg;

	localparam int COLOR_W   = 8;
	localparam int SLOT_W    = 8;
	localparam int CNT_W     = 9;
	localparam int CFG_IDX_W = 2;
	localparam int SQ_W      = 2 * COLOR_W;
	localparam int DIST_W    = SQ_W + 2;
	localparam int ENTRY_W   = 3 * COLOR_W;

	localparam logic [COLOR_W-1:0] ALPHA_OPAQUE_MIN = 8'd128;

	// Input item opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESERVE     = 2'd1;

	localparam logic [CNT_W-1:0] COLOR_COUNT_RST = 9'd256;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_DIRECT = 2'd2
	} cmd_kind_t;

	// One classified item between front and back.
	//   CMD_WRITE : slot = palette entry, rgb = color
	//   CMD_SEARCH: slot = first entry, last = last entry, rgb = pixel
	//   CMD_DIRECT: slot = palette index to return
	typedef struct packed {
		cmd_kind_t           kind;
		logic [SLOT_W-1:0]   slot;
		logic [SLOT_W-1:0]   last;
		logic [COLOR_W-1:0]  red;
		logic [COLOR_W-1:0]  green;
		logic [COLOR_W-1:0]  blue;
	} cmd_t;

endpackage

`default_nettype wire

### rtl/nearest_palette_color_mapper_core.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_mapper_core
// Maps RGBA pixels to the index of the nearest palette color.
//
// Input channel (in_valid / in_stall): each beat is either a palette write
// (opcode 0: entry_index, red, green, blue) or a pixel (opcode 1: red, green,
// blue, alpha). A pixel beat yields one palette_index beat on the output
// channel (out_valid / out_stall); a palette write yields none.
// Configuration channel (cfg_valid / cfg_ready, always ready): index 0 sets
// color_count, index 1 sets reserve_transparent; other indexes are ignored.
// Write configuration only while no pixel is in flight.
//
// A search runs from the queue head through the scan, the read, square and
// accumulate stages and the output register; transparent pixels and empty
// search ranges go from the head to the output register. The scan takes one
// palette entry per cycle through the single shared distance unit, and no
// new item leaves the queue until a search is done. A two-entry queue lets
// the front take beats while a search runs. Reset empties the queue and the
// pipeline and sets color_count to 256 and reserve_transparent to 0; the
// palette itself holds garbage until written. A stalled output holds its
// beat, the back end waits on it, and once the queue fills in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_mapper_core #(
	parameter int PALETTE_DEPTH = 256
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration write channel
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [npcm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [npcm_pkg::CNT_W-1:0]       cfg_data,
	// input channel
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             opcode,
	input  wire logic [npcm_pkg::SLOT_W-1:0]      entry_index,
	input  wire logic [npcm_pkg::COLOR_W-1:0]     red,
	input  wire logic [npcm_pkg::COLOR_W-1:0]     green,
	input  wire logic [npcm_pkg::COLOR_W-1:0]     blue,
	input  wire logic [npcm_pkg::COLOR_W-1:0]     alpha,
	// output channel
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [npcm_pkg::SLOT_W-1:0]           palette_index
);
	import npcm_pkg::*;

	logic q_full;
	logic q_push;
	cmd_t q_cmd;
	logic q_pop;
	logic q_head_valid;
	cmd_t q_head_cmd;

	// Front: accept beats, hold config, classify
	npcm_front #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.entry_index (entry_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.alpha       (alpha),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (q_cmd)
	);

	// Queue: decouple front from back
	npcm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_cmd   (q_head_cmd)
	);

	// Back: palette memory, search, output register
	npcm_back #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (q_head_valid),
		.head_cmd      (q_head_cmd),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.palette_index (palette_index)
	);

endmodule

`default_nettype wire

### rtl/npcm_front.sv
// ----------------------------------------------------------------------------
// npcm_front
// Accepts input beats, holds the configuration registers and classifies each
// item into a palette write, a direct answer or a palette search.
// ----------------------------------------------------------------------------
`default_nettype none

module npcm_front #(
	parameter int PALETTE_DEPTH = 256
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [npcm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [npcm_pkg::CNT_W-1:0]       cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             opcode,
	input  wire logic [npcm_pkg::SLOT_W-1:0]      entry_index,
	input  wire logic [npcm_pkg::COLOR_W-1:0]     red,
	input  wire logic [npcm_pkg::COLOR_W-1:0]     green,
	input  wire logic [npcm_pkg::COLOR_W-1:0]     blue,
	input  wire logic [npcm_pkg::COLOR_W-1:0]     alpha,
	input  wire logic                             q_full,
	output logic                                  q_push,
	output npcm_pkg::cmd_t                        q_cmd
);
	import npcm_pkg::*;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PALETTE_DEPTH);

	logic [CNT_W-1:0] color_count_q;
	logic             reserve_q;
	logic [CNT_W-1:0] limit;
	logic [CNT_W-1:0] first;
	logic             slot_ok;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_count_q <= COLOR_COUNT_RST;
			reserve_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_COLOR_COUNT: color_count_q <= cfg_data;
				CFG_RESERVE:     reserve_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Saturate the count at the palette depth
	assign limit   = (color_count_q > DEPTH_CNT) ? DEPTH_CNT : color_count_q;
	assign first   = {{(CNT_W-1){1'b0}}, reserve_q};
	assign slot_ok = ({1'b0, entry_index} < DEPTH_CNT);

	always_comb begin
		q_cmd.kind  = CMD_SEARCH;
		q_cmd.slot  = SLOT_W'(first);
		q_cmd.last  = SLOT_W'(limit - CNT_W'(1));
		q_cmd.red   = red;
		q_cmd.green = green;
		q_cmd.blue  = blue;
		if (opcode == OP_WRITE) begin
			q_cmd.kind = CMD_WRITE;
			q_cmd.slot = entry_index;
		end else if (reserve_q && (alpha < ALPHA_OPAQUE_MIN)) begin
			q_cmd.kind = CMD_DIRECT;
			q_cmd.slot = '0;
		end else if (limit <= first) begin
			q_cmd.kind = CMD_DIRECT;
		end
	end

	assign in_stall = q_full;
	// Drop writes to slots beyond the palette
	assign q_push   = in_valid && !q_full && ((opcode != OP_WRITE) || slot_ok);

endmodule

`default_nettype wire

### rtl/npcm_queue.sv
// ----------------------------------------------------------------------------
// npcm_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module npcm_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire npcm_pkg::cmd_t  push_cmd,
	output logic                 full,
	input  wire logic            pop,
	output logic                 head_valid,
	output npcm_pkg::cmd_t       head_cmd
);
	import npcm_pkg::*;

	cmd_t       slots_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_cmd   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/npcm_back.sv
// ----------------------------------------------------------------------------
// npcm_back
// Palette memory, sequential nearest-color search and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module npcm_back #(
	parameter int PALETTE_DEPTH = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          head_valid,
	input  wire npcm_pkg::cmd_t                head_cmd,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [npcm_pkg::SLOT_W-1:0]        palette_index
);
	import npcm_pkg::*;

	localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	logic [ENTRY_W-1:0] mem_q [PALETTE_DEPTH];

	logic [IDX_W-1:0]   ptr_q;
	logic [IDX_W-1:0]   first_q;
	logic [IDX_W-1:0]   last_q;
	logic [COLOR_W-1:0] pix_r_q;
	logic [COLOR_W-1:0] pix_g_q;
	logic [COLOR_W-1:0] pix_b_q;

	logic [ENTRY_W-1:0] rd_data_s1;
	logic               valid_s1;
	logic               head_s1;
	logic [IDX_W-1:0]   idx_s1;

	logic [SQ_W-1:0]    sq_r_s2;
	logic [SQ_W-1:0]    sq_g_s2;
	logic [SQ_W-1:0]    sq_b_s2;
	logic               valid_s2;
	logic               head_s2;
	logic [IDX_W-1:0]   idx_s2;

	logic [DIST_W-1:0]  best_d_q;
	logic [IDX_W-1:0]   best_q;

	logic               out_free;
	logic               load_out;
	logic [SLOT_W-1:0]  load_idx;
	logic               start;
	logic               mem_we;
	logic [COLOR_W-1:0] dr;
	logic [COLOR_W-1:0] dg;
	logic [COLOR_W-1:0] db;
	logic [DIST_W-1:0]  dist_sum;

	function automatic logic [COLOR_W-1:0] absdiff(
		input logic [COLOR_W-1:0] a,
		input logic [COLOR_W-1:0] b
	);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	assign out_free = !out_valid || !out_stall;

	// Control decode of the queue head and the output load
	always_comb begin
		pop      = 1'b0;
		start    = 1'b0;
		mem_we   = 1'b0;
		load_out = 1'b0;
		load_idx = SLOT_W'(best_q);
		unique case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					unique case (head_cmd.kind)
						CMD_WRITE: begin
							pop    = 1'b1;
							mem_we = 1'b1;
						end
						CMD_SEARCH: begin
							pop   = 1'b1;
							start = 1'b1;
						end
						CMD_DIRECT: begin
							pop      = out_free;
							load_out = out_free;
							load_idx = head_cmd.slot;
						end
						default: ;
					endcase
				end
			end
			ST_DONE: load_out = out_free;
			default: ;
		endcase
	end

	// Palette memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[head_cmd.slot[IDX_W-1:0]] <= {head_cmd.red, head_cmd.green, head_cmd.blue};
		end
		rd_data_s1 <= mem_q[ptr_q];
	end

	// Search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (start) state_q <= ST_SCAN;
				ST_SCAN:  if (ptr_q == last_q) state_q <= ST_DRAIN;
				ST_DRAIN: if (!valid_s1 && !valid_s2) state_q <= ST_DONE;
				ST_DONE:  if (out_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ptr_q   <= head_cmd.slot[IDX_W-1:0];
			first_q <= head_cmd.slot[IDX_W-1:0];
			last_q  <= head_cmd.last[IDX_W-1:0];
			pix_r_q <= head_cmd.red;
			pix_g_q <= head_cmd.green;
			pix_b_q <= head_cmd.blue;
		end else if (state_q == ST_SCAN) begin
			ptr_q <= ptr_q + IDX_W'(1);
		end
	end

	// Distance pipeline: read, square, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN);
			valid_s2 <= valid_s1;
		end
	end

	assign dr = absdiff(pix_r_q, rd_data_s1[ENTRY_W-1 -: COLOR_W]);
	assign dg = absdiff(pix_g_q, rd_data_s1[2*COLOR_W-1 -: COLOR_W]);
	assign db = absdiff(pix_b_q, rd_data_s1[COLOR_W-1:0]);

	always_ff @(posedge clk) begin
		idx_s1  <= ptr_q;
		head_s1 <= (ptr_q == first_q);
		sq_r_s2 <= SQ_W'(dr) * SQ_W'(dr);
		sq_g_s2 <= SQ_W'(dg) * SQ_W'(dg);
		sq_b_s2 <= SQ_W'(db) * SQ_W'(db);
		idx_s2  <= idx_s1;
		head_s2 <= head_s1;
	end

	assign dist_sum = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);

	// Strict compare keeps the lowest index on ties
	always_ff @(posedge clk) begin
		if (valid_s2 && (head_s2 || (dist_sum < best_d_q))) begin
			best_d_q <= dist_sum;
			best_q   <= idx_s2;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			palette_index <= load_idx;
		end
	end

endmodule

`default_nettype wire
